FILE: sv/tsgc_pkg.sv
package tsgc_pkg;

   localparam int unsigned PosW    = 7;
   localparam int unsigned TolW    = 8;
   localparam int unsigned WindowW = 16;
   localparam int unsigned CsrW    = 16;
   localparam int unsigned CsrIdxW = 2;

   localparam logic [TolW-1:0]    SlideTolReset  = TolW'(10);
   localparam logic [WindowW-1:0] WindowReset    = WindowW'(300);
   localparam logic [PosW-1:0]    PosThreshReset = PosW'(15);

   typedef enum logic [1:0] {
      FUNC_PRESS   = 2'd0,
      FUNC_RELEASE = 2'd1,
      FUNC_SAMPLE  = 2'd2,
      FUNC_TICK    = 2'd3
   } func_type;

   typedef enum logic [1:0] {
      MODE_IDLE    = 2'd0,
      MODE_TOUCHED = 2'd1,
      MODE_SLIDING = 2'd2,
      MODE_WAITING = 2'd3
   } mode_type;

   typedef enum logic [CsrIdxW-1:0] {
      CSR_SLIDE_TOL  = 2'd0,
      CSR_WINDOW     = 2'd1,
      CSR_POS_THRESH = 2'd2
   } csr_idx_type;

   typedef struct packed {
      func_type        func;
      logic [PosW-1:0] position;
   } req_type;

   typedef struct packed {
      logic            position_valid;
      logic [PosW-1:0] current_position;
      logic            is_sliding;
      logic            double_tap;
      logic            single_tap;
      logic [PosW-1:0] start_position;
      mode_type        gesture_mode;
   } rsp_type;

   typedef struct packed {
      logic [TolW-1:0]    slide_tolerance;
      logic [WindowW-1:0] double_window_ms;
      logic [PosW-1:0]    position_threshold;
   } cfg_type;

   typedef struct packed {
      mode_type           mode;
      logic [WindowW-1:0] since_release_ms;
      logic [PosW-1:0]    first_pos;
      logic [TolW-1:0]    sample_count;
      logic [PosW-1:0]    last_pos;
      logic               finger_down;
   } state_type;

endpackage

FILE: sv/tsgc_update.sv
module tsgc_update (
   input  tsgc_pkg::state_type state,
   input  tsgc_pkg::cfg_type   cfg,
   input  tsgc_pkg::req_type   req,
   output tsgc_pkg::state_type state_next,
   output tsgc_pkg::rsp_type   rsp
);
   import tsgc_pkg::*;

   logic [PosW-1:0]    diff;
   logic               near_and_soon;
   logic               short_touch;
   logic [TolW-1:0]    count_inc;
   logic [WindowW-1:0] since_inc;
   logic               dbl;
   logic               sgl;

   assign diff = (req.position > state.first_pos) ? req.position - state.first_pos
                                                  : state.first_pos - req.position;
   assign short_touch = state.sample_count <= cfg.slide_tolerance;
   assign near_and_soon = (state.mode == MODE_WAITING)
                          && (state.since_release_ms < cfg.double_window_ms)
                          && (diff < cfg.position_threshold)
                          && short_touch;
   assign count_inc = (state.sample_count == {TolW{1'b1}}) ? state.sample_count
                                                           : state.sample_count + 1'b1;
   assign since_inc = (state.since_release_ms == {WindowW{1'b1}})
                      ? state.since_release_ms : state.since_release_ms + 1'b1;

   always_comb begin
      state_next = state;
      dbl = 1'b0;
      sgl = 1'b0;
      case (req.func)
         FUNC_PRESS: begin
            state_next.finger_down = 1'b1;
            state_next.last_pos = req.position;
            if (near_and_soon) begin
               dbl = 1'b1;
            end else begin
               state_next.first_pos = req.position;
            end
            state_next.mode = MODE_TOUCHED;
            state_next.sample_count = '0;
         end
         FUNC_RELEASE: begin
            state_next.finger_down = 1'b0;
            state_next.last_pos = req.position;
            if (short_touch) begin
               state_next.mode = MODE_WAITING;
               state_next.since_release_ms = '0;
            end else begin
               state_next.mode = MODE_IDLE;
            end
            state_next.sample_count = '0;
         end
         FUNC_SAMPLE: begin
            state_next.last_pos = req.position;
            state_next.sample_count = count_inc;
            if ((count_inc > cfg.slide_tolerance) && (state.mode == MODE_TOUCHED)) begin
               state_next.mode = MODE_SLIDING;
            end
         end
         FUNC_TICK: begin
            state_next.since_release_ms = since_inc;
            if ((state.mode == MODE_WAITING) && (since_inc > cfg.double_window_ms)) begin
               state_next.mode = MODE_IDLE;
               sgl = 1'b1;
            end
         end
         default: begin
            state_next = state;
         end
      endcase
   end

   always_comb begin
      rsp.position_valid   = state_next.finger_down;
      rsp.current_position = state_next.finger_down ? state_next.last_pos : '0;
      rsp.is_sliding       = state_next.mode == MODE_SLIDING;
      rsp.double_tap       = dbl;
      rsp.single_tap       = sgl;
      rsp.start_position   = state_next.first_pos;
      rsp.gesture_mode     = state_next.mode;
   end

endmodule

FILE: sv/touch_slider_gesture_classifier.sv
// touch slider gesture classifier
// request channel (req_valid, req_stall, req_data): one event per request,
// either a press, a release, a position sample or a millisecond tick, with
// the slider position (ignored for ticks).
// response channel (rsp_valid, rsp_stall, rsp_data): exactly one response
// per request, in order, showing finger state, current and start position,
// gesture mode and one-response tap and double-tap pulses.
// csr port (csr_we, csr_index, csr_wdata): writes slide tolerance, double-tap
// window and position threshold; unused indexes are ignored. write only
// while no request is in flight.
// the response is registered at the edge that accepts the request.
// throughput is one request per cycle while the response is not stalled,
// set by the single gesture state update between the state registers and
// the response register.
// reset clears the gesture state, restores the register defaults and
// empties the response register.
// while the response is stalled, req_stall is high and the held response
// does not change; the request is taken in the same cycle the response
// leaves.
module touch_slider_gesture_classifier (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  tsgc_pkg::req_type                      req_data,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output tsgc_pkg::rsp_type                      rsp_data,
   input  logic                                   csr_we,
   input  logic [tsgc_pkg::CsrIdxW-1:0]           csr_index,
   input  logic [tsgc_pkg::CsrW-1:0]              csr_wdata
);
   import tsgc_pkg::*;

   cfg_type   cfg_ff, cfg_in;
   state_type state_ff, state_in;
   rsp_type   rsp_ff, rsp_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      req_take;

   assign req_stall = rsp_valid_ff && rsp_stall;
   assign req_take  = req_valid && !req_stall;

   tsgc_update u_update (
      .state      (state_ff),
      .cfg        (cfg_ff),
      .req        (req_data),
      .state_next (state_in),
      .rsp        (rsp_in)
   );

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_idx_type'(csr_index))
            CSR_SLIDE_TOL:  cfg_in.slide_tolerance = csr_wdata[TolW-1:0];
            CSR_WINDOW:     cfg_in.double_window_ms = csr_wdata[WindowW-1:0];
            CSR_POS_THRESH: cfg_in.position_threshold = csr_wdata[PosW-1:0];
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   assign rsp_valid_in = req_take || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.slide_tolerance    <= SlideTolReset;
         cfg_ff.double_window_ms   <= WindowReset;
         cfg_ff.position_threshold <= PosThreshReset;
         state_ff.mode             <= MODE_IDLE;
         state_ff.since_release_ms <= '0;
         state_ff.first_pos        <= '0;
         state_ff.sample_count     <= '0;
         state_ff.last_pos         <= '0;
         state_ff.finger_down      <= 1'b0;
         rsp_valid_ff              <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         rsp_valid_ff <= rsp_valid_in;
         if (req_take) begin
            state_ff <= state_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_data.double_tap && rsp_data.single_tap))
      else $error("tap and double tap in one response");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.single_tap) |-> (rsp_data.gesture_mode == MODE_IDLE))
      else $error("single tap without return to idle");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.double_tap)
      |-> (rsp_data.gesture_mode == MODE_TOUCHED && rsp_data.position_valid))
      else $error("double tap outside a touch");

   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> rsp_valid)
      else $error("accepted request gave no response");

endmodule

FILE: bench/touch_slider_gesture_classifier_tb.sv
module touch_slider_gesture_classifier_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import tsgc_pkg::*;

   localparam logic [CsrIdxW-1:0] CSR_SPARE = 2'd3;

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_stall;
   req_type           req_data;
   logic              rsp_valid;
   logic              rsp_stall;
   rsp_type           rsp_data;
   logic              csr_we;
   logic [CsrIdxW-1:0] csr_index;
   logic [CsrW-1:0]   csr_wdata;

   // predictor copy of the gesture state and registers
   logic [TolW-1:0]    tol_cfg;
   logic [WindowW-1:0] window_cfg;
   logic [PosW-1:0]    thresh_cfg;
   mode_type           g_mode;
   logic [WindowW-1:0] ms_since_release;
   logic [PosW-1:0]    anchor_pos;
   logic [TolW-1:0]    sample_cnt;
   logic [PosW-1:0]    recent_pos;
   logic               finger_on;

   rsp_type     predicted_gestures[$];
   int unsigned events_sent;
   int unsigned mismatches;
   bit          idling_on;

   touch_slider_gesture_classifier dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #4_000_000;
      $display("touch_slider_gesture_classifier verification failed");
      $finish;
   end

   function automatic rsp_type predict_gesture(req_type ev);
      logic [PosW-1:0] pos_gap;
      logic            is_double;
      rsp_type         r;
      r = '0;
      case (ev.func)
         FUNC_PRESS: begin
            pos_gap = (ev.position > anchor_pos) ? ev.position - anchor_pos
                                                 : anchor_pos - ev.position;
            is_double = (g_mode == MODE_WAITING) && (ms_since_release < window_cfg)
                        && (pos_gap < thresh_cfg) && (sample_cnt <= tol_cfg);
            finger_on = 1'b1;
            recent_pos = ev.position;
            if (is_double) begin
               r.double_tap = 1'b1;
            end else begin
               anchor_pos = ev.position;
            end
            g_mode = MODE_TOUCHED;
            sample_cnt = '0;
         end
         FUNC_RELEASE: begin
            finger_on = 1'b0;
            recent_pos = ev.position;
            if (sample_cnt <= tol_cfg) begin
               g_mode = MODE_WAITING;
               ms_since_release = '0;
            end else begin
               g_mode = MODE_IDLE;
            end
            sample_cnt = '0;
         end
         FUNC_SAMPLE: begin
            recent_pos = ev.position;
            if (sample_cnt != '1) sample_cnt = sample_cnt + 1'b1;
            if (sample_cnt > tol_cfg && g_mode == MODE_TOUCHED) g_mode = MODE_SLIDING;
         end
         default: begin
            if (ms_since_release != '1) ms_since_release = ms_since_release + 1'b1;
            if (g_mode == MODE_WAITING && ms_since_release > window_cfg) begin
               g_mode = MODE_IDLE;
               r.single_tap = 1'b1;
            end
         end
      endcase
      r.position_valid   = finger_on;
      r.current_position = finger_on ? recent_pos : '0;
      r.is_sliding       = (g_mode == MODE_SLIDING);
      r.start_position   = anchor_pos;
      r.gesture_mode     = g_mode;
      return r;
   endfunction

   task automatic compare_field(string field, int unsigned want, int unsigned got);
      if (want != got) begin
         mismatches++;
         $display("%0t: %s expected %0d actual %0d", $time, field, want, got);
      end
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (predicted_gestures.size() == 0) begin
            mismatches++;
            $display("%0t: response expected none actual %h", $time, rsp_data);
         end else begin
            want = predicted_gestures.pop_front();
            compare_field("position_valid", want.position_valid, rsp_data.position_valid);
            compare_field("current_position", want.current_position,
                          rsp_data.current_position);
            compare_field("is_sliding", want.is_sliding, rsp_data.is_sliding);
            compare_field("double_tap", want.double_tap, rsp_data.double_tap);
            compare_field("single_tap", want.single_tap, rsp_data.single_tap);
            compare_field("start_position", want.start_position, rsp_data.start_position);
            compare_field("gesture_mode", want.gesture_mode, rsp_data.gesture_mode);
         end
      end
   end

   always @(negedge clock) begin
      rsp_stall = idling_on && ($urandom_range(99) < 27);
   end

   // called at a falling edge, returns at a falling edge with valid still high
   task automatic send_event(func_type f, logic [PosW-1:0] pos);
      while (idling_on && $urandom_range(99) < 27) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid = 1'b1;
      req_data  = '{func: f, position: pos};
      do @(posedge clock); while (req_stall);
      predicted_gestures.push_back(predict_gesture(req_data));
      events_sent++;
      @(negedge clock);
   endtask

   task automatic drain_requests();
      req_valid = 1'b0;
      while (predicted_gestures.size() != 0) @(negedge clock);
      repeat (2) @(negedge clock);
   endtask

   task automatic write_csr(logic [CsrIdxW-1:0] idx, logic [CsrW-1:0] value);
      csr_we    = 1'b1;
      csr_index = idx;
      csr_wdata = value;
      @(negedge clock);
      csr_we = 1'b0;
      case (idx)
         CSR_SLIDE_TOL:  tol_cfg = value[TolW-1:0];
         CSR_WINDOW:     window_cfg = value;
         CSR_POS_THRESH: thresh_cfg = value[PosW-1:0];
         default: ;
      endcase
   endtask

   function automatic logic [PosW-1:0] near_anchor();
      int p;
      p = int'(anchor_pos) + int'($urandom_range(0, 40)) - 20;
      if (p < 0) p = 0;
      if (p > 127) p = 127;
      return PosW'(p);
   endfunction

   function automatic logic [PosW-1:0] any_position();
      return ($urandom_range(9) == 0) ? PosW'($urandom_range(101, 127))
                                      : PosW'($urandom_range(0, 100));
   endfunction

   task automatic test_directed_events();
      send_event(FUNC_PRESS, 7'd100);
      send_event(FUNC_SAMPLE, 7'd127);
      send_event(FUNC_RELEASE, 7'd127);
      send_event(FUNC_PRESS, 7'd110);
      send_event(FUNC_RELEASE, 7'd0);
      send_event(FUNC_PRESS, 7'd0);
      for (int i = 1; i <= 11; i++) send_event(FUNC_SAMPLE, PosW'(i));
      send_event(FUNC_RELEASE, 7'd11);
      send_event(FUNC_RELEASE, 7'd42);
      send_event(FUNC_TICK, 7'd127);
      send_event(FUNC_TICK, 7'd0);
      send_event(FUNC_PRESS, 7'd85);
      send_event(FUNC_RELEASE, 7'd85);
      send_event(FUNC_PRESS, 7'd64);
      send_event(FUNC_PRESS, 7'd64);
      drain_requests();
   endtask

   task automatic test_register_extremes();
      // shortest windows
      write_csr(CSR_WINDOW, 16'd1);
      send_event(FUNC_PRESS, 7'd40);
      send_event(FUNC_RELEASE, 7'd40);
      repeat (3) send_event(FUNC_TICK, 7'd40);
      drain_requests();
      write_csr(CSR_WINDOW, 16'd0);
      send_event(FUNC_PRESS, 7'd40);
      send_event(FUNC_RELEASE, 7'd41);
      send_event(FUNC_PRESS, 7'd40);
      send_event(FUNC_RELEASE, 7'd40);
      send_event(FUNC_TICK, 7'd40);
      drain_requests();
      // zero tolerance slides on the first sample
      write_csr(CSR_SLIDE_TOL, 16'hFF00);
      send_event(FUNC_PRESS, 7'd10);
      send_event(FUNC_SAMPLE, 7'd10);
      send_event(FUNC_RELEASE, 7'd10);
      drain_requests();
      // full tolerance never slides, sample count saturates
      write_csr(CSR_SLIDE_TOL, 16'h00FF);
      write_csr(CSR_WINDOW, 16'd5);
      send_event(FUNC_PRESS, 7'd20);
      repeat (260) send_event(FUNC_SAMPLE, PosW'($urandom_range(0, 127)));
      send_event(FUNC_RELEASE, 7'd20);
      send_event(FUNC_PRESS, 7'd20);
      drain_requests();
      write_csr(CSR_POS_THRESH, 16'hFF80);
      send_event(FUNC_RELEASE, 7'd20);
      send_event(FUNC_PRESS, 7'd20);
      drain_requests();
      write_csr(CSR_POS_THRESH, 16'h007F);
      send_event(FUNC_RELEASE, 7'd20);
      send_event(FUNC_PRESS, 7'd100);
      drain_requests();
      // spare index must leave all registers alone
      write_csr(CSR_SPARE, 16'hFFFF);
      send_event(FUNC_RELEASE, 7'd101);
      send_event(FUNC_PRESS, 7'd90);
      send_event(FUNC_TICK, 7'd0);
      drain_requests();
   endtask

   task automatic test_long_window();
      idling_on = 1'b0;
      write_csr(CSR_WINDOW, 16'd65534);
      write_csr(CSR_SLIDE_TOL, 16'd10);
      send_event(FUNC_PRESS, 7'd60);
      send_event(FUNC_RELEASE, 7'd60);
      repeat (40) send_event(FUNC_TICK, PosW'($urandom_range(0, 127)));
      send_event(FUNC_PRESS, 7'd60);
      drain_requests();
      idling_on = 1'b1;
   endtask

   task automatic test_random_gestures(int unsigned n_events, bit quiet);
      logic [TolW-1:0]    tol;
      logic [WindowW-1:0] win;
      logic [PosW-1:0]    thr;
      logic [PosW-1:0]    p;
      int unsigned        target;
      int unsigned        n;
      case ($urandom_range(0, 4))
         0:       tol = '0;
         1:       tol = $urandom_range(0, 1) ? 8'd254 : 8'd255;
         default: tol = TolW'($urandom_range(1, 15));
      endcase
      case ($urandom_range(0, 5))
         0:       win = 16'd1;
         1:       win = $urandom_range(0, 1) ? 16'd65534 : 16'd65535;
         default: win = WindowW'($urandom_range(2, 30));
      endcase
      case ($urandom_range(0, 5))
         0:       thr = '0;
         1:       thr = 7'd101;
         2:       thr = 7'd127;
         default: thr = PosW'($urandom_range(5, 40));
      endcase
      write_csr(CSR_SLIDE_TOL, {8'($urandom), tol});
      write_csr(CSR_WINDOW, win);
      write_csr(CSR_POS_THRESH, {9'($urandom), thr});
      idling_on = !quiet;
      target = events_sent + n_events;
      while (events_sent < target) begin
         if ($urandom_range(99) < 15) begin
            send_event(func_type'($urandom_range(0, 3)), PosW'($urandom_range(0, 127)));
         end else begin
            p = $urandom_range(0, 1) ? near_anchor() : any_position();
            send_event(FUNC_PRESS, p);
            n = $urandom_range(0, (tol_cfg > 11) ? 14 : tol_cfg + 3);
            repeat (n) begin
               p = near_anchor();
               send_event(FUNC_SAMPLE, p);
            end
            send_event(FUNC_RELEASE, $urandom_range(0, 3) ? p : any_position());
            n = $urandom_range(0, (window_cfg > 37) ? 40 : window_cfg + 3);
            repeat (n) send_event(FUNC_TICK, PosW'($urandom_range(0, 127)));
            if ($urandom_range(99) < 4) drain_requests();
         end
      end
      drain_requests();
      idling_on = 1'b1;
   endtask

   initial begin
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_data    = '0;
      rsp_stall   = 1'b0;
      csr_we      = 1'b0;
      csr_index   = '0;
      csr_wdata   = '0;
      idling_on   = 1'b1;
      events_sent = 0;
      mismatches  = 0;
      tol_cfg          = SlideTolReset;
      window_cfg       = WindowReset;
      thresh_cfg       = PosThreshReset;
      g_mode           = MODE_IDLE;
      ms_since_release = '0;
      anchor_pos       = '0;
      sample_cnt       = '0;
      recent_pos       = '0;
      finger_on        = 1'b0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      @(negedge clock);

      test_directed_events();
      test_register_extremes();
      test_long_window();
      for (int ph = 0; ph < 6; ph++) test_random_gestures(50, ph == 3);
      drain_requests();
      repeat (4) @(negedge clock);

      if (mismatches == 0 && predicted_gestures.size() == 0) begin
         $display("touch_slider_gesture_classifier verification clean");
      end else begin
         $display("touch_slider_gesture_classifier verification failed");
      end
      $finish;
   end

endmodule
